// ===== rtl/core/value_noise_terrain_classifier_macros.svh =====
// Assertion macros used by the value noise terrain classifier queue.
`ifndef VALUE_NOISE_TERRAIN_CLASSIFIER_MACROS_SVH
`define VALUE_NOISE_TERRAIN_CLASSIFIER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define VNTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a condition in the next.
`define VNTC_ASSERT_NEXT(lbl, cond, expect_next, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_next)) \
      else $error(msg);

`endif

// ===== rtl/core/vntc_pkg.sv =====
// Types, constants and arithmetic helpers of the value noise terrain classifier.
package vntc_pkg;

   localparam int CoordWidth = 8;
   localparam int DivSteps = CoordWidth;
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = 2;
   localparam int QueueCountWidth = 3;
   localparam int GridSize = 4;

   localparam logic [7:0] ThreshWater = 8'd80;
   localparam logic [7:0] ThreshGrass = 8'd120;
   localparam logic [7:0] ThreshTrees = 8'd160;

   localparam logic [1:0] TerrainGrass = 2'h0;
   localparam logic [1:0] TerrainWater = 2'h1;
   localparam logic [1:0] TerrainTrees = 2'h2;
   localparam logic [1:0] TerrainMountains = 2'h3;

   localparam logic CsrIdxSeed = 1'b0;
   localparam logic CsrIdxScale = 1'b1;

   localparam logic [7:0] SeedReset = 8'd0;
   localparam logic [7:0] ScaleReset = 8'd1;

   typedef struct packed {
      logic [7:0] coord_x;
      logic [7:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [7:0] noise_value;
      logic [1:0] terrain_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] cx;
      logic [7:0] cy;
   } cell_type;

   typedef struct packed {
      logic [15:0] ax;
      logic [15:0] ay;
   } div_stage_type;

   // One restoring division step: upper byte is the remainder, lower byte
   // shifts the dividend out and the quotient in.
   function automatic logic [15:0] div_step(input logic [15:0] aq, input logic [7:0] d);
      logic [8:0] a;
      logic [8:0] diff;
      logic [15:0] r;
      a = {aq[15:8], aq[7]};
      diff = a - {1'b0, d};
      if (a >= {1'b0, d}) begin
         r = {diff[7:0], aq[6:0], 1'b1};
      end else begin
         r = {a[7:0], aq[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] hash8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] s);
      logic [7:0] t;
      logic [7:0] u;
      logic [7:0] h;
      t = a ^ s ^ b;
      u = b + t;
      h = (s + {1'b0, u[7:1]}) ^ t;
      return h;
   endfunction

   function automatic logic [1:0] classify(input logic [7:0] v);
      logic [1:0] code;
      if (v < ThreshWater) begin
         code = TerrainWater;
      end else if (v < ThreshGrass) begin
         code = TerrainGrass;
      end else if (v < ThreshTrees) begin
         code = TerrainTrees;
      end else begin
         code = TerrainMountains;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/vntc_front.sv =====
// Front end: accepts coordinates and finds the lattice cell in a pipelined divider.
module vntc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           scale,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vntc_pkg::req_type    req_data,
   output logic                 cell_valid,
   input  logic                 cell_stall,
   output vntc_pkg::cell_type   cell_data
);

   localparam int Last = vntc_pkg::DivSteps - 1;

   vntc_pkg::div_stage_type stage_ff [vntc_pkg::DivSteps];
   vntc_pkg::div_stage_type stage_in [vntc_pkg::DivSteps];
   logic [vntc_pkg::DivSteps-1:0] valid_ff;
   logic [7:0] divisor;
   logic advance;

   assign divisor = (scale == 8'd0) ? 8'd1 : scale;
   assign advance = !(valid_ff[Last] && cell_stall);
   assign req_stall = !advance;

   always_comb begin
      stage_in[0].ax = vntc_pkg::div_step({8'd0, req_data.coord_x}, divisor);
      stage_in[0].ay = vntc_pkg::div_step({8'd0, req_data.coord_y}, divisor);
      for (int i = 1; i < vntc_pkg::DivSteps; i++) begin
         stage_in[i].ax = vntc_pkg::div_step(stage_ff[i-1].ax, divisor);
         stage_in[i].ay = vntc_pkg::div_step(stage_ff[i-1].ay, divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[vntc_pkg::DivSteps-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_valid = valid_ff[Last];
   assign cell_data.cx = stage_ff[Last].ax[7:0];
   assign cell_data.cy = stage_ff[Last].ay[7:0];

endmodule

// ===== rtl/core/vntc_queue.sv =====
// Short queue of lattice cells between the front end and the back end.
`include "value_noise_terrain_classifier_macros.svh"

module vntc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  vntc_pkg::cell_type   in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output vntc_pkg::cell_type   out_data
);

   vntc_pkg::cell_type mem_ff [vntc_pkg::QueueDepth];
   logic [vntc_pkg::QueuePtrWidth-1:0] wr_ptr_ff;
   logic [vntc_pkg::QueuePtrWidth-1:0] wr_ptr_in;
   logic [vntc_pkg::QueuePtrWidth-1:0] rd_ptr_ff;
   logic [vntc_pkg::QueuePtrWidth-1:0] rd_ptr_in;
   logic [vntc_pkg::QueueCountWidth-1:0] count_ff;
   logic [vntc_pkg::QueueCountWidth-1:0] count_in;
   logic full;
   logic push;
   logic pop;

   assign full = (count_ff == vntc_pkg::QueueCountWidth'(vntc_pkg::QueueDepth));
   assign in_stall = full;
   assign out_valid = (count_ff != '0);
   assign push = in_valid && !full;
   assign pop = out_valid && !out_stall;
   assign out_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `VNTC_ASSERT(a_count_bound, count_ff <= vntc_pkg::QueueCountWidth'(vntc_pkg::QueueDepth), "queue count beyond depth")
   `VNTC_ASSERT(a_empty_ptrs, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff), "empty queue with unequal pointers")
   `VNTC_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `VNTC_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not shrink on pop")

endmodule

// ===== rtl/core/vntc_back.sv =====
// Back end: hashes the lattice window, smooths, interpolates and classifies.
module vntc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           seed,
   input  logic                 cell_valid,
   output logic                 cell_stall,
   input  vntc_pkg::cell_type   cell_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vntc_pkg::rsp_type    rsp_data
);

   logic [7:0] hash_ff [vntc_pkg::GridSize][vntc_pkg::GridSize];
   logic [7:0] hash_in [vntc_pkg::GridSize][vntc_pkg::GridSize];
   logic [7:0] smooth_ff [4];
   logic [7:0] smooth_in [4];
   logic hash_valid_ff;
   logic smooth_valid_ff;
   logic rsp_valid_ff;
   vntc_pkg::rsp_type rsp_ff;
   vntc_pkg::rsp_type rsp_in;
   logic [7:0] xs [vntc_pkg::GridSize];
   logic [7:0] ys [vntc_pkg::GridSize];
   logic advance;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign cell_stall = !advance;

   always_comb begin
      for (int i = 0; i < vntc_pkg::GridSize; i++) begin
         xs[i] = cell_data.cx - 8'd1 + 8'(i);
         ys[i] = cell_data.cy - 8'd1 + 8'(i);
      end
      for (int j = 0; j < vntc_pkg::GridSize; j++) begin
         for (int i = 0; i < vntc_pkg::GridSize; i++) begin
            hash_in[j][i] = vntc_pkg::hash8(xs[i], ys[j], seed);
         end
      end
   end

   always_comb begin
      logic [9:0] diag;
      logic [9:0] side;
      for (int b = 0; b < 2; b++) begin
         for (int a = 0; a < 2; a++) begin
            diag = {2'b0, hash_ff[b][a]} + {2'b0, hash_ff[b][a+2]}
                 + {2'b0, hash_ff[b+2][a]} + {2'b0, hash_ff[b+2][a+2]};
            side = {2'b0, hash_ff[b+1][a]} + {2'b0, hash_ff[b+1][a+2]}
                 + {2'b0, hash_ff[b][a+1]} + {2'b0, hash_ff[b+2][a+1]};
            smooth_in[2*b+a] = 8'(diag >> 4) + 8'(side >> 3) + (hash_ff[b+1][a+1] >> 2);
         end
      end
   end

   always_comb begin
      logic [8:0] top;
      logic [8:0] bot;
      logic [8:0] mix;
      top = {1'b0, smooth_ff[0]} + {1'b0, smooth_ff[1]};
      bot = {1'b0, smooth_ff[2]} + {1'b0, smooth_ff[3]};
      mix = {1'b0, top[8:1]} + {1'b0, bot[8:1]};
      rsp_in.noise_value = mix[8:1];
      rsp_in.terrain_code = vntc_pkg::classify(mix[8:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_valid_ff <= 1'b0;
         smooth_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         hash_valid_ff <= cell_valid;
         smooth_valid_ff <= hash_valid_ff;
         rsp_valid_ff <= smooth_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hash_ff <= hash_in;
         smooth_ff <= smooth_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/value_noise_terrain_classifier.sv =====
// Top level of the value noise terrain classifier with its register port.
// Each result passes through the divider, the cell queue and then the back end.
// Throughput: one transaction per cycle unless stalled, set by an 8-stage divider
// pipeline in the front end and the 3-stage hash, smooth and blend pipeline in the back.
// A 4-entry cell queue lets the front end keep accepting while results stall.
// Synchronous reset empties all stages and the queue, sets seed to 0, scale to 1.
module value_noise_terrain_classifier (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vntc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vntc_pkg::rsp_type    rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   logic [7:0] seed_ff;
   logic [7:0] seed_in;
   logic [7:0] scale_ff;
   logic [7:0] scale_in;
   logic csr_write;
   logic front_valid;
   logic front_stall;
   vntc_pkg::cell_type front_cell;
   logic back_valid;
   logic back_stall;
   vntc_pkg::cell_type back_cell;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in = seed_ff;
      scale_in = scale_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            vntc_pkg::CsrIdxSeed: seed_in = csr_pwdata[7:0];
            vntc_pkg::CsrIdxScale: scale_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         vntc_pkg::CsrIdxSeed: csr_prdata = {24'd0, seed_ff};
         vntc_pkg::CsrIdxScale: csr_prdata = {24'd0, scale_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= vntc_pkg::SeedReset;
         scale_ff <= vntc_pkg::ScaleReset;
      end else begin
         seed_ff <= seed_in;
         scale_ff <= scale_in;
      end
   end

   vntc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .scale      (scale_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cell_valid (front_valid),
      .cell_stall (front_stall),
      .cell_data  (front_cell)
   );

   vntc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_cell),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_data  (back_cell)
   );

   vntc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .cell_valid (back_valid),
      .cell_stall (back_stall),
      .cell_data  (back_cell),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sim/value_noise_terrain_classifier_tb.sv =====
// Self-checking testbench for the value noise terrain classifier with a tile noise predictor.
module value_noise_terrain_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;
   localparam int HoldCycles = 300;
   localparam int SettleCycles = 16;
   localparam logic [2:0] SeedAddr = {vntc_pkg::CsrIdxSeed, 2'b00};
   localparam logic [2:0] ScaleAddr = {vntc_pkg::CsrIdxScale, 2'b00};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   vntc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   vntc_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic [7:0]        cur_seed;
   logic [7:0]        cur_scale;
   vntc_pkg::rsp_type expected_tiles[$];
   int                error_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                quiet_cycles;
   logic              rsp_hold_active;
   event              rsp_hold_ev;

   value_noise_terrain_classifier uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] lattice_hash(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] t;
      logic [7:0] u;
      logic [7:0] h;
      t = a ^ cur_seed ^ b;
      u = b + t;
      h = cur_seed + (u >> 1);
      return h ^ t;
   endfunction

   function automatic logic [7:0] smooth_point(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] xm;
      logic [7:0] xp;
      logic [7:0] ym;
      logic [7:0] yp;
      logic [9:0] diag;
      logic [9:0] side;
      logic [9:0] total;
      xm = x - 8'd1;
      xp = x + 8'd1;
      ym = y - 8'd1;
      yp = y + 8'd1;
      diag = 10'(lattice_hash(xm, ym)) + 10'(lattice_hash(xp, ym))
           + 10'(lattice_hash(xm, yp)) + 10'(lattice_hash(xp, yp));
      side = 10'(lattice_hash(xm, y)) + 10'(lattice_hash(xp, y))
           + 10'(lattice_hash(x, ym)) + 10'(lattice_hash(x, yp));
      total = (diag >> 4) + (side >> 3) + (10'(lattice_hash(x, y)) >> 2);
      return total[7:0];
   endfunction

   function automatic logic [7:0] mean_of(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic vntc_pkg::rsp_type predict_tile(input logic [7:0] x,
                                                      input logic [7:0] y);
      logic [7:0] divisor;
      logic [7:0] cx;
      logic [7:0] cy;
      logic [7:0] top;
      logic [7:0] bottom;
      vntc_pkg::rsp_type r;
      divisor = (cur_scale == 8'd0) ? 8'd1 : cur_scale;
      cx = x / divisor;
      cy = y / divisor;
      top = mean_of(smooth_point(cx, cy), smooth_point(cx + 8'd1, cy));
      bottom = mean_of(smooth_point(cx, cy + 8'd1), smooth_point(cx + 8'd1, cy + 8'd1));
      r.noise_value = mean_of(top, bottom);
      if (r.noise_value < vntc_pkg::ThreshWater) begin
         r.terrain_code = vntc_pkg::TerrainWater;
      end else if (r.noise_value < vntc_pkg::ThreshGrass) begin
         r.terrain_code = vntc_pkg::TerrainGrass;
      end else if (r.noise_value < vntc_pkg::ThreshTrees) begin
         r.terrain_code = vntc_pkg::TerrainTrees;
      end else begin
         r.terrain_code = vntc_pkg::TerrainMountains;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      if (rsp_hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always begin
      @(rsp_hold_ev);
      rsp_hold_active = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      rsp_hold_active = 1'b0;
   end

   always @(posedge clock) begin
      vntc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tiles.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_data.noise_value, 0);
         end else begin
            want = expected_tiles.pop_front();
            if (rsp_data.noise_value !== want.noise_value) begin
               report_mismatch("noise_value", rsp_data.noise_value, want.noise_value);
            end
            if (rsp_data.terrain_code !== want.terrain_code) begin
               report_mismatch("terrain_code", rsp_data.terrain_code, want.terrain_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("TIMEOUT: no transaction for %0d cycles", WatchdogLimit);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_tile(input logic [7:0] x, input logic [7:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data <= vntc_pkg::req_type'(16'($urandom));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data.coord_x <= x;
      req_data.coord_y <= y;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_tiles.push_back(predict_tile(x, y));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tiles.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (addr == SeedAddr) cur_seed = value;
      else cur_scale = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[7:0] !== value) begin
         report_mismatch("register readback", csr_prdata[7:0], value);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_terrain(input logic [7:0] seed_val, input logic [7:0] scale_val);
      write_reg(SeedAddr, seed_val);
      write_reg(ScaleAddr, scale_val);
   endtask

   task automatic test_reset_defaults();
      send_tile(8'd0, 8'd0);
      send_tile(8'd255, 8'd255);
      send_tile(8'd0, 8'd255);
      send_tile(8'd255, 8'd0);
      wait_drained();
   endtask

   task automatic test_zero_scale();
      set_terrain(8'h00, 8'd0);
      send_tile(8'd0, 8'd0);
      send_tile(8'd255, 8'd255);
      send_tile(8'd200, 8'd13);
      wait_drained();
   endtask

   task automatic test_largest_scale();
      set_terrain(8'h3C, 8'd255);
      send_tile(8'd254, 8'd254);
      send_tile(8'd255, 8'd0);
      send_tile(8'd255, 8'd255);
      wait_drained();
   endtask

   task automatic test_seed_extremes();
      set_terrain(8'hFF, 8'd1);
      send_tile(8'hAA, 8'h55);
      send_tile(8'h55, 8'hAA);
      send_tile(8'd255, 8'd255);
      wait_drained();
      set_terrain(8'h5A, 8'd16);
      send_tile(8'd15, 8'd16);
      send_tile(8'd16, 8'd15);
      send_tile(8'd240, 8'd255);
      send_tile(8'd127, 8'd128);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_terrain(8'($urandom), 8'd3);
      -> rsp_hold_ev;
      repeat (40) send_tile(8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   task automatic test_random_tiles(input int idle_pct, input int stall_pct, input int count);
      logic [7:0] scale_val;
      logic [7:0] x;
      logic [7:0] y;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int setting = 0; setting < 4; setting++) begin
         case ($urandom_range(5))
            0: scale_val = 8'd0;
            1: scale_val = 8'd1;
            2: scale_val = 8'd255;
            3: scale_val = 8'($urandom_range(2, 8));
            default: scale_val = 8'($urandom);
         endcase
         set_terrain(8'($urandom), scale_val);
         for (int n = 0; n < count / 4; n++) begin
            x = 8'($urandom);
            y = 8'($urandom);
            if ($urandom_range(9) == 0) x = ($urandom_range(1)) ? 8'($urandom_range(1)) : 8'd255 - 8'($urandom_range(1));
            if ($urandom_range(9) == 0) y = ($urandom_range(1)) ? 8'($urandom_range(1)) : 8'd255 - 8'($urandom_range(1));
            send_tile(x, y);
         end
         wait_drained();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_seed = vntc_pkg::SeedReset;
      cur_scale = vntc_pkg::ScaleReset;
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 7;
      rsp_stall_pct = 70;
      rsp_hold_active = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_scale();
      test_largest_scale();
      test_seed_extremes();
      test_backpressure();
      test_random_tiles(7, 70, 580);
      test_random_tiles(70, 7, 580);
      test_random_tiles(0, 0, 580);

      if (error_count == 0 && expected_tiles.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
